// ===== rtl/h2r_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// h2r_pkg: shared types and constants of the HSV to RGB converter
// Field widths, hue wrap and sector constants, reciprocal constants and the
// payload structs that travel between the pipeline sections.
// ----------------------------------------------------------------------------
package h2r_pkg;

  // Port field widths.
  localparam int HUE_W  = 16;
  localparam int SAT_W  = 14;
  localparam int VAL_W  = 14;
  localparam int GAIN_W = 10;
  localparam int CH_W   = 15;

  // Gain register reset, about 1.30 in 1/256 units.
  localparam logic [GAIN_W-1:0] GAIN_RESET = 10'd333;

  // Hue wrap: a bias that is a multiple of the full turn makes the hue positive.
  localparam int HUE_FULL   = 3600;
  localparam int HUE_SECTOR = 600;
  localparam int HUE_BIAS   = 36000;
  localparam int U_W        = 17;
  localparam int H_W        = 12;
  localparam int QH_W       = 5;
  localparam int HUE_SHIFT  = 26;
  localparam logic [14:0] HUE_RECIP = 15'd18641;

  // Secondary component: product of chroma and ramp, divided by 8 then by 75.
  localparam int T_W     = 10;
  localparam int P_W     = 25;
  localparam int P8_W    = 22;
  localparam int X_DIV   = 75;
  localparam int X_SHIFT = 22;
  localparam logic [15:0] X_RECIP = 16'd55924;

  localparam logic [CH_W-1:0] CH_MAX = '1;

  // Sixty-degree hue sectors.
  typedef enum logic [2:0] {
    SEC_RED_YEL = 3'd0,
    SEC_YEL_GRN = 3'd1,
    SEC_GRN_CYN = 3'd2,
    SEC_CYN_BLU = 3'd3,
    SEC_BLU_MAG = 3'd4,
    SEC_MAG_RED = 3'd5
  } sector_t;

  // Wrapped hue, scaled value and chroma.
  typedef struct packed {
    logic [H_W-1:0]  h;
    logic [CH_W-1:0] v;
    logic [CH_W-1:0] c;
  } prep_t;

  // Sector, chroma, offset, estimated secondary and the dividend it came from.
  typedef struct packed {
    sector_t         sector;
    logic [CH_W-1:0] c;
    logic [CH_W-1:0] m;
    logic [CH_W-1:0] qx;
    logic [P8_W-1:0] p8;
  } ramp_t;

endpackage

// ===== rtl/h2r_ifs.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// h2r_ifs: stream channels of the HSV to RGB converter
// Valid/ready channels for the HSV input beat and the RGB result beat.
// ----------------------------------------------------------------------------
interface h2r_in_if import h2r_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [HUE_W-1:0] hue_tenths;
  logic signed [SAT_W-1:0] saturation_in;
  logic signed [VAL_W-1:0] value_in;

  modport source (output valid, output hue_tenths, output saturation_in,
                  output value_in, input ready);
  modport sink   (input valid, input hue_tenths, input saturation_in,
                  input value_in, output ready);
endinterface

interface h2r_out_if import h2r_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [CH_W-1:0] red;
  logic [CH_W-1:0] green;
  logic [CH_W-1:0] blue;

  modport source (output valid, output red, output green, output blue,
                  input ready);
  modport sink   (input valid, input red, input green, input blue,
                  output ready);
endinterface

// ===== rtl/hsv_to_rgb_converter.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsv_to_rgb_converter: fixed-point HSV to RGB conversion pipeline
// Wraps hue, clamps saturation, scales value by a programmable gain and
// produces red, green and blue through a six-stage pipeline.
//
//   Channel | Direction | Beat contents
//   --------+-----------+------------------------------------------------
//   in_ch   | sink      | hue_tenths, saturation_in, value_in
//   out_ch  | source    | red, green, blue
//   cfg_*   | write     | value_gain, taken whenever cfg_wr_en is high
//
// One beat is accepted per cycle while no back-pressure holds the pipeline; a
// result passes one register per stage through six stages up to and
// including the output register.
// Each stage holds its own valid bit and moves when empty or when the next
// stage takes its beat, so a stall fills bubbles and drops nothing.
// Reset clears the valid bits and loads the gain with about 1.30; there is
// no clearing pass.
// ----------------------------------------------------------------------------
module hsv_to_rgb_converter import h2r_pkg::*; #(
  parameter int FRAC_BITS = 12
) (
  input  logic              clk,
  input  logic              rst_n,
  h2r_in_if.sink            in_ch,
  h2r_out_if.source         out_ch,
  input  logic              cfg_wr_en,
  input  logic [GAIN_W-1:0] cfg_wr_data
);

  logic [GAIN_W-1:0] value_gain_r;
  logic              prep_valid, prep_ready;
  logic              ramp_valid, ramp_ready;
  prep_t             prep_data;
  ramp_t             ramp_data;

  // Gain register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      value_gain_r <= GAIN_RESET;
    end else if (cfg_wr_en) begin
      value_gain_r <= cfg_wr_data;
    end
  end

  // Hue wrap, clamp, gain and chroma.
  h2r_prep #(
    .FRAC_BITS (FRAC_BITS)
  ) u_prep (
    .clk           (clk),
    .rst_n         (rst_n),
    .up_valid      (in_ch.valid),
    .up_ready      (in_ch.ready),
    .hue_tenths    (in_ch.hue_tenths),
    .saturation_in (in_ch.saturation_in),
    .value_in      (in_ch.value_in),
    .value_gain    (value_gain_r),
    .dn_valid      (prep_valid),
    .dn_ready      (prep_ready),
    .dn_data       (prep_data)
  );

  // Sector decode and secondary estimate.
  h2r_ramp u_ramp (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (prep_valid),
    .up_ready (prep_ready),
    .up_data  (prep_data),
    .dn_valid (ramp_valid),
    .dn_ready (ramp_ready),
    .dn_data  (ramp_data)
  );

  // Channel assembly and output register.
  h2r_mix u_mix (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (ramp_valid),
    .up_ready (ramp_ready),
    .up_data  (ramp_data),
    .out_ch   (out_ch)
  );

endmodule

// ===== rtl/h2r_prep.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// h2r_prep: hue wrap, saturation clamp, value gain and chroma
// Two register stages: the first multiplies hue by a reciprocal and value by
// the gain, the second finishes the hue remainder and forms the chroma.
// ----------------------------------------------------------------------------
module h2r_prep import h2r_pkg::*; #(
  parameter int FRAC_BITS = 12
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    up_valid,
  output logic                    up_ready,
  input  logic signed [HUE_W-1:0] hue_tenths,
  input  logic signed [SAT_W-1:0] saturation_in,
  input  logic signed [VAL_W-1:0] value_in,
  input  logic [GAIN_W-1:0]       value_gain,
  output logic                    dn_valid,
  input  logic                    dn_ready,
  output prep_t                   dn_data
);

  localparam int S_W  = FRAC_BITS + 1;
  localparam int ONE  = 1 << FRAC_BITS;
  localparam int CP_W = CH_W + S_W;
  localparam int VP_W = VAL_W - 1 + GAIN_W;

  logic                    vld1_r, vld2_r;
  logic                    st1_rdy, st2_rdy;
  logic [U_W-1:0]          u1_r, u1_nxt;
  logic [QH_W-1:0]         qh1_r, qh1_nxt;
  logic [S_W-1:0]          s1_r, s1_nxt;
  logic [CH_W-1:0]         v1_r, v1_nxt;
  logic [U_W+14:0]         hq_prod;
  logic [VP_W-1:0]         vg_prod;
  logic [U_W-1:0]          hue_base, hue_rem;
  logic [CP_W-1:0]         cs_prod;
  prep_t                   st2_r, st2_nxt;

  // Each stage moves when it is empty or the next one takes its beat.
  assign st2_rdy  = !vld2_r || dn_ready;
  assign st1_rdy  = !vld1_r || st2_rdy;
  assign up_ready = st1_rdy;
  assign dn_valid = vld2_r;
  assign dn_data  = st2_r;

  // Stage 1: biased hue and its quotient estimate, clamped saturation, gain.
  always_comb begin
    u1_nxt  = U_W'(int'(hue_tenths) + HUE_BIAS);
    hq_prod = u1_nxt * HUE_RECIP;
    qh1_nxt = hq_prod[HUE_SHIFT +: QH_W];
    if (saturation_in < 0) begin
      s1_nxt = '0;
    end else if (int'(saturation_in) > ONE) begin
      s1_nxt = S_W'(ONE);
    end else begin
      s1_nxt = S_W'(saturation_in[SAT_W-2:0]);
    end
    vg_prod = value_in[VAL_W-2:0] * value_gain;
    v1_nxt  = (value_in > 0) ? vg_prod[VP_W-1 -: CH_W] : '0;
  end

  // Stage 2: the estimate is at most one short, so one subtract corrects it.
  always_comb begin
    hue_base  = U_W'(qh1_r * HUE_FULL);
    hue_rem   = u1_r - hue_base;
    st2_nxt.h = (hue_rem >= U_W'(HUE_FULL)) ? H_W'(hue_rem - U_W'(HUE_FULL))
                                            : H_W'(hue_rem);
    cs_prod   = v1_r * s1_r;
    st2_nxt.v = v1_r;
    st2_nxt.c = cs_prod[FRAC_BITS +: CH_W];
  end

  // Valid bits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r <= 1'b0;
      vld2_r <= 1'b0;
    end else begin
      if (st1_rdy) begin
        vld1_r <= up_valid;
      end
      if (st2_rdy) begin
        vld2_r <= vld1_r;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (st1_rdy && up_valid) begin
      u1_r  <= u1_nxt;
      qh1_r <= qh1_nxt;
      s1_r  <= s1_nxt;
      v1_r  <= v1_nxt;
    end
    if (st2_rdy && vld1_r) begin
      st2_r <= st2_nxt;
    end
  end

`ifndef ASSERT_OFF
  // The corrected hue remainder always lies inside one turn.
  a_hue_wrapped: assert property (@(posedge clk) disable iff (!rst_n)
    vld2_r |-> (st2_r.h < H_W'(HUE_FULL)))
    else $error("wrapped hue out of range");

  // Chroma never exceeds the scaled value, so the offset cannot go negative.
  a_chroma_le_value: assert property (@(posedge clk) disable iff (!rst_n)
    vld2_r |-> (st2_r.c <= st2_r.v))
    else $error("chroma above value");
`endif

endmodule

// ===== rtl/h2r_ramp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// h2r_ramp: sector decode and secondary component estimate
// Three register stages: sector and ramp position, chroma times ramp, and a
// reciprocal multiply that estimates the quotient by 600.
// ----------------------------------------------------------------------------
module h2r_ramp import h2r_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  up_valid,
  output logic  up_ready,
  input  prep_t up_data,
  output logic  dn_valid,
  input  logic  dn_ready,
  output ramp_t dn_data
);

  logic              vld3_r, vld4_r, vld5_r;
  logic              st3_rdy, st4_rdy, st5_rdy;
  sector_t           sec3_r, sec3_nxt, sec4_r;
  logic [H_W-1:0]    sec_base, ramp_pos;
  logic [T_W-1:0]    t3_r, t3_nxt;
  logic [CH_W-1:0]   c3_r, m3_r, m3_nxt, c4_r, m4_r;
  logic [P_W-1:0]    ct_prod;
  logic [P8_W-1:0]   p84_r;
  logic [P8_W+15:0]  est_prod;
  ramp_t             st5_r, st5_nxt;

  assign st5_rdy  = !vld5_r || dn_ready;
  assign st4_rdy  = !vld4_r || st5_rdy;
  assign st3_rdy  = !vld3_r || st4_rdy;
  assign up_ready = st3_rdy;
  assign dn_valid = vld5_r;
  assign dn_data  = st5_r;

  // Stage 3: find the sector; odd sectors run the ramp downward.
  always_comb begin
    if (up_data.h >= H_W'(5 * HUE_SECTOR)) begin
      sec3_nxt = SEC_MAG_RED;
      sec_base = H_W'(5 * HUE_SECTOR);
    end else if (up_data.h >= H_W'(4 * HUE_SECTOR)) begin
      sec3_nxt = SEC_BLU_MAG;
      sec_base = H_W'(4 * HUE_SECTOR);
    end else if (up_data.h >= H_W'(3 * HUE_SECTOR)) begin
      sec3_nxt = SEC_CYN_BLU;
      sec_base = H_W'(3 * HUE_SECTOR);
    end else if (up_data.h >= H_W'(2 * HUE_SECTOR)) begin
      sec3_nxt = SEC_GRN_CYN;
      sec_base = H_W'(2 * HUE_SECTOR);
    end else if (up_data.h >= H_W'(HUE_SECTOR)) begin
      sec3_nxt = SEC_YEL_GRN;
      sec_base = H_W'(HUE_SECTOR);
    end else begin
      sec3_nxt = SEC_RED_YEL;
      sec_base = '0;
    end
    ramp_pos = up_data.h - sec_base;
    t3_nxt   = sec3_nxt[0] ? (T_W'(HUE_SECTOR) - ramp_pos[T_W-1:0])
                           : ramp_pos[T_W-1:0];
    m3_nxt   = up_data.v - up_data.c;
  end

  // Stage 4: chroma times ramp position; the low three bits drop with the 8.
  assign ct_prod = c3_r * t3_r;

  // Stage 5: quotient by 75 from a reciprocal, at most one short.
  always_comb begin
    est_prod       = p84_r * X_RECIP;
    st5_nxt.sector = sec4_r;
    st5_nxt.c      = c4_r;
    st5_nxt.m      = m4_r;
    st5_nxt.qx     = est_prod[X_SHIFT +: CH_W];
    st5_nxt.p8     = p84_r;
  end

  // Valid bits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld3_r <= 1'b0;
      vld4_r <= 1'b0;
      vld5_r <= 1'b0;
    end else begin
      if (st3_rdy) begin
        vld3_r <= up_valid;
      end
      if (st4_rdy) begin
        vld4_r <= vld3_r;
      end
      if (st5_rdy) begin
        vld5_r <= vld4_r;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (st3_rdy && up_valid) begin
      sec3_r <= sec3_nxt;
      t3_r   <= t3_nxt;
      c3_r   <= up_data.c;
      m3_r   <= m3_nxt;
    end
    if (st4_rdy && vld3_r) begin
      sec4_r <= sec3_r;
      c4_r   <= c3_r;
      m4_r   <= m3_r;
      p84_r  <= ct_prod[P_W-1:P_W-P8_W];
    end
    if (st5_rdy && vld4_r) begin
      st5_r <= st5_nxt;
    end
  end

`ifndef ASSERT_OFF
  // The estimate leaves a remainder below two divisors, so one step corrects.
  a_estimate_close: assert property (@(posedge clk) disable iff (!rst_n)
    vld5_r |-> ((st5_r.p8 - P8_W'(st5_r.qx * X_DIV)) < P8_W'(2 * X_DIV)))
    else $error("secondary estimate off by more than one");

  // A beat held in stage 3 while stage 4 is blocked stays there.
  a_stage3_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (vld3_r && !st4_rdy) |=> (vld3_r && $stable(t3_r) && $stable(c3_r)))
    else $error("stalled beat lost in stage 3");
`endif

endmodule

// ===== rtl/h2r_mix.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// h2r_mix: secondary correction, channel assignment and output register
// Finishes the quotient by 600, places chroma and secondary by sector, adds
// the offset and saturates each channel into the output register.
// ----------------------------------------------------------------------------
module h2r_mix import h2r_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       up_valid,
  output logic       up_ready,
  input  ramp_t      up_data,
  h2r_out_if.source  out_ch
);

  logic [P8_W-1:0] x_rem;
  logic [CH_W-1:0] x_val;
  logic [CH_W-1:0] ch_r, ch_g, ch_b;
  logic [CH_W-1:0] red_r, green_r, blue_r;
  logic [CH_W-1:0] red_nxt, green_nxt, blue_nxt;
  logic            out_vld_r;

  // Adds the offset and clamps at the channel maximum.
  function automatic logic [CH_W-1:0] sat_add(input logic [CH_W-1:0] a,
                                               input logic [CH_W-1:0] b);
    logic [CH_W:0] sum;
    sum = {1'b0, a} + {1'b0, b};
    return sum[CH_W] ? CH_MAX : sum[CH_W-1:0];
  endfunction

  assign up_ready     = !out_vld_r || out_ch.ready;
  assign out_ch.valid = out_vld_r;
  assign out_ch.red   = red_r;
  assign out_ch.green = green_r;
  assign out_ch.blue  = blue_r;

  // Correct the quotient estimate by one where the remainder allows it.
  always_comb begin
    x_rem = up_data.p8 - P8_W'(up_data.qx * X_DIV);
    x_val = (x_rem >= P8_W'(X_DIV)) ? (up_data.qx + CH_W'(1)) : up_data.qx;
  end

  // Place chroma and secondary by sector.
  always_comb begin
    unique case (up_data.sector)
      SEC_RED_YEL: begin
        ch_r = up_data.c; ch_g = x_val;     ch_b = '0;
      end
      SEC_YEL_GRN: begin
        ch_r = x_val;     ch_g = up_data.c; ch_b = '0;
      end
      SEC_GRN_CYN: begin
        ch_r = '0;        ch_g = up_data.c; ch_b = x_val;
      end
      SEC_CYN_BLU: begin
        ch_r = '0;        ch_g = x_val;     ch_b = up_data.c;
      end
      SEC_BLU_MAG: begin
        ch_r = x_val;     ch_g = '0;        ch_b = up_data.c;
      end
      default: begin
        ch_r = up_data.c; ch_g = '0;        ch_b = x_val;
      end
    endcase
    red_nxt   = sat_add(ch_r, up_data.m);
    green_nxt = sat_add(ch_g, up_data.m);
    blue_nxt  = sat_add(ch_b, up_data.m);
  end

  // Output valid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (up_ready) begin
      out_vld_r <= up_valid;
    end
  end

  // Output payload.
  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      red_r   <= red_nxt;
      green_r <= green_nxt;
      blue_r  <= blue_nxt;
    end
  end

`ifndef ASSERT_OFF
  // The corrected secondary component never exceeds the chroma.
  a_secondary_le_chroma: assert property (@(posedge clk) disable iff (!rst_n)
    (up_valid && up_ready) |-> (x_val <= up_data.c))
    else $error("secondary component above chroma");
`endif

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the HSV to RGB converter
// Drives HSV beats over the input channel, predicts every RGB beat from an
// integer copy of the conversion and compares each result beat field by field
// in order. Directed colors and gain extremes are run first, then random
// traffic under several patterns of sender idling and receiver back-pressure.
// ----------------------------------------------------------------------------
module tb;
  import h2r_pkg::*;

  localparam int FRAC_BITS   = 12;
  localparam int UNIT_ONE    = 1 << FRAC_BITS;
  localparam int DRAIN_WAIT  = 10;
  localparam int CYCLE_LIMIT = 100000;
  localparam int REPORT_MAX  = 10;

  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
  } rgb_t;

  logic              clk;
  logic              rst_n;
  logic              cfg_wr_en;
  logic [GAIN_W-1:0] cfg_wr_data;

  h2r_in_if  hsv_ch ();
  h2r_out_if rgb_ch ();

  // Gain that the block holds, mirrored for the prediction.
  logic [GAIN_W-1:0] gain_shadow;
  rgb_t              rgb_expected_q[$];
  int                mismatch_count;
  int                send_idle_pct;
  int                recv_stall_pct;
  int                cycle_count;

  hsv_to_rgb_converter #(
    .FRAC_BITS(FRAC_BITS)
  ) DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (hsv_ch.sink),
    .out_ch     (rgb_ch.source),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  // Clock with a 20 ns period.
  initial clk = 1'b0;
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Clamp a channel sum to the largest output code.
  function automatic logic [CH_W-1:0] clip_channel(longint sum);
    if (sum > longint'(CH_MAX)) begin
      return CH_MAX;
    end
    return sum[CH_W-1:0];
  endfunction

  // Integer HSV to RGB conversion at the block's widths.
  function automatic rgb_t hsv_to_rgb_expect(logic signed [HUE_W-1:0] hue,
                                             logic signed [SAT_W-1:0] sat,
                                             logic signed [VAL_W-1:0] val,
                                             logic [GAIN_W-1:0] gain);
    longint  h, s, v, c, x, m, ramp;
    sector_t sec;
    rgb_t    res;
    h = longint'(hue) % HUE_FULL;
    if (h < 0) begin
      h = h + HUE_FULL;
    end
    if (sat < 0) begin
      s = 0;
    end else if (longint'(sat) > UNIT_ONE) begin
      s = UNIT_ONE;
    end else begin
      s = longint'(sat);
    end
    if (val <= 0) begin
      v = 0;
    end else begin
      v = (longint'(val) * longint'({1'b0, gain})) >> 8;
    end
    c    = (v * s) >> FRAC_BITS;
    sec  = sector_t'(h / HUE_SECTOR);
    ramp = h % HUE_SECTOR;
    // Even sectors ramp the secondary up, odd sectors ramp it down.
    if (sec[0] == 1'b0) begin
      x = (c * ramp) / HUE_SECTOR;
    end else begin
      x = (c * (HUE_SECTOR - ramp)) / HUE_SECTOR;
    end
    m = v - c;
    case (sec)
      SEC_RED_YEL: begin
        res.red = clip_channel(c + m); res.green = clip_channel(x + m);
        res.blue = clip_channel(m);
      end
      SEC_YEL_GRN: begin
        res.red = clip_channel(x + m); res.green = clip_channel(c + m);
        res.blue = clip_channel(m);
      end
      SEC_GRN_CYN: begin
        res.red = clip_channel(m); res.green = clip_channel(c + m);
        res.blue = clip_channel(x + m);
      end
      SEC_CYN_BLU: begin
        res.red = clip_channel(m); res.green = clip_channel(x + m);
        res.blue = clip_channel(c + m);
      end
      SEC_BLU_MAG: begin
        res.red = clip_channel(x + m); res.green = clip_channel(m);
        res.blue = clip_channel(c + m);
      end
      default: begin
        res.red = clip_channel(c + m); res.green = clip_channel(m);
        res.blue = clip_channel(x + m);
      end
    endcase
    return res;
  endfunction

  task automatic note_mismatch(string msg);
    mismatch_count++;
    if (mismatch_count <= REPORT_MAX) begin
      $display("%s", msg);
    end
  endtask

  // Send one HSV beat, with random idle cycles ahead of it.
  task automatic send_hsv(logic signed [HUE_W-1:0] hue, logic signed [SAT_W-1:0] sat,
                          logic signed [VAL_W-1:0] val);
    @(negedge clk);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      hsv_ch.valid <= 1'b0;
      @(negedge clk);
    end
    hsv_ch.valid         <= 1'b1;
    hsv_ch.hue_tenths    <= hue;
    hsv_ch.saturation_in <= sat;
    hsv_ch.value_in      <= val;
    do begin
      @(posedge clk);
    end while (!hsv_ch.ready);
    rgb_expected_q.push_back(hsv_to_rgb_expect(hue, sat, val, gain_shadow));
  endtask

  // Drop valid and wait until every predicted result beat has been seen.
  task automatic drain_results();
    @(negedge clk);
    hsv_ch.valid <= 1'b0;
    while (rgb_expected_q.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  // Write the gain register while the pipeline is empty.
  task automatic write_gain(logic [GAIN_W-1:0] gain);
    drain_results();
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= gain;
    gain_shadow = gain;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  // Mostly well-formed colors, the rest spread over the whole field range.
  task automatic send_random_hsv();
    logic signed [HUE_W-1:0] hue;
    logic signed [SAT_W-1:0] sat;
    logic signed [VAL_W-1:0] val;
    if ($urandom_range(0, 9) < 6) begin
      hue = HUE_W'($urandom_range(0, HUE_FULL - 1));
      sat = SAT_W'($urandom_range(0, UNIT_ONE));
      val = VAL_W'($urandom_range(1, (1 << (VAL_W - 1)) - 1));
    end else begin
      hue = HUE_W'($urandom);
      sat = SAT_W'($urandom);
      val = VAL_W'($urandom);
    end
    send_hsv(hue, sat, val);
  endtask

  // Sector boundaries, hue wrap and the clamps of saturation and value.
  task automatic test_directed_colors();
    send_hsv(16'sd0,      14'sd4096,  14'sd8191);
    send_hsv(16'sd600,    14'sd4096,  14'sd8191);
    send_hsv(16'sd1200,   14'sd4096,  14'sd8191);
    send_hsv(16'sd1800,   14'sd4096,  14'sd8191);
    send_hsv(16'sd2400,   14'sd4096,  14'sd8191);
    send_hsv(16'sd3000,   14'sd4096,  14'sd8191);
    send_hsv(16'sd3599,   14'sd4096,  14'sd8191);
    send_hsv(16'sd3600,   14'sd4096,  14'sd4000);
    send_hsv(-16'sd1,     14'sd4096,  14'sd4000);
    send_hsv(-16'sd32768, 14'sd8191,  14'sd8191);
    send_hsv(16'sd32767,  -14'sd8192, 14'sd8191);
    send_hsv(16'sd300,    14'sd4097,  14'sd5000);
    send_hsv(16'sd300,    -14'sd1,    14'sd5000);
    send_hsv(16'sd900,    14'sd0,     14'sd5000);
    send_hsv(16'sd900,    14'sd2048,  14'sd0);
    send_hsv(16'sd900,    14'sd2048,  -14'sd1);
    send_hsv(16'sd900,    14'sd2048,  -14'sd8192);
    send_hsv(16'sd150,    14'sd3000,  14'sd1);
    send_hsv(16'sd4500,   14'sd2048,  14'sd6000);
    send_hsv(-16'sd3601,  14'sd4096,  14'sd6000);
  endtask

  // Zero gain blacks everything out; the largest gain gives the brightest codes.
  task automatic test_gain_extremes();
    write_gain('0);
    send_hsv(16'sd450,  14'sd4096, 14'sd8191);
    send_hsv(16'sd2100, 14'sd1000, 14'sd3000);
    write_gain('1);
    send_hsv(16'sd0,    14'sd4096, 14'sd8191);
    send_hsv(16'sd1799, 14'sd8191, 14'sd8191);
    send_hsv(16'sd2950, 14'sd0,    14'sd8191);
  endtask

  task automatic test_random_traffic(int idle_pct, int stall_pct,
                                     logic [GAIN_W-1:0] gain, int count);
    write_gain(gain);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    repeat (count) send_random_hsv();
  endtask

  // Receiver back-pressure, redrawn every cycle.
  always @(negedge clk) begin
    rgb_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // Compare every accepted result beat with the oldest prediction.
  always @(posedge clk) begin
    rgb_t want;
    if (rst_n && rgb_ch.valid && rgb_ch.ready) begin
      if (rgb_expected_q.size() == 0) begin
        note_mismatch($sformatf("unexpected result beat r=%0d g=%0d b=%0d",
                                rgb_ch.red, rgb_ch.green, rgb_ch.blue));
      end else begin
        want = rgb_expected_q.pop_front();
        if (rgb_ch.red !== want.red || rgb_ch.green !== want.green ||
            rgb_ch.blue !== want.blue) begin
          note_mismatch($sformatf("mismatch: expected r=%0d g=%0d b=%0d, got r=%0d g=%0d b=%0d",
                                  want.red, want.green, want.blue,
                                  rgb_ch.red, rgb_ch.green, rgb_ch.blue));
        end
      end
    end
  end

  // Cycle counter that stops a hung run.
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("hsv_to_rgb_converter test failed");
    $finish;
  end

  initial begin
    rst_n                = 1'b0;
    cfg_wr_en            = 1'b0;
    cfg_wr_data          = '0;
    hsv_ch.valid         = 1'b0;
    hsv_ch.hue_tenths    = '0;
    hsv_ch.saturation_in = '0;
    hsv_ch.value_in      = '0;
    rgb_ch.ready         = 1'b0;
    gain_shadow          = GAIN_RESET;
    mismatch_count       = 0;
    send_idle_pct        = 0;
    recv_stall_pct       = 0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_directed_colors();
    test_gain_extremes();
    test_random_traffic(0,  0,  GAIN_W'($urandom), 150);
    test_random_traffic(72, 0,  '1,                150);
    test_random_traffic(0,  72, GAIN_W'($urandom), 150);
    test_random_traffic(15, 15, GAIN_RESET,        150);
    drain_results();

    if (mismatch_count == 0) begin
      $display("hsv_to_rgb_converter test passed");
    end else begin
      $display("hsv_to_rgb_converter test failed");
    end
    $finish;
  end

endmodule
